@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// overlapping implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/ostw_pkg.sv @@
// shared constants and types for the waveshaper
package ostw_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int SAMPLE_BITS = 16;
	localparam int ENTRY_W     = 9;
	localparam int FRAC_BITS   = SAMPLE_BITS - 1;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int IDX_FRAC_W  = FRAC_BITS - ADDR_W;
	localparam int LAST_IDX    = TABLE_DEPTH - 1;
	localparam int MAX_VAL     = 2 ** FRAC_BITS - 1;

	// reset ramp round(i*MAX_VAL/LAST_IDX) built by quotient/remainder stepping
	localparam int RAMP_QSTEP = MAX_VAL / LAST_IDX;
	localparam int RAMP_RSTEP = MAX_VAL % LAST_IDX;
	localparam int RAMP_RINIT = LAST_IDX / 2;
	localparam int RAMP_R_W   = ADDR_W + 1;

	// operation codes
	localparam logic OP_SHAPE = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// per-sample control carried alongside the table reads
	typedef struct packed {
		logic                          pass;
		logic                          neg;
		logic [IDX_FRAC_W-1:0]         frac;
		logic signed [SAMPLE_BITS-1:0] sample;
	} ctl_t;

endpackage

@@ rtl/ostw_table.sv @@
// transfer table memory with reset ramp fill and two registered read ports
module ostw_table (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   rd_en,
	input  logic [ostw_pkg::ADDR_W-1:0]            rd_addr_a,
	input  logic [ostw_pkg::ADDR_W-1:0]            rd_addr_b,
	input  logic                                   wr_en,
	input  logic [ostw_pkg::ADDR_W-1:0]            wr_addr,
	input  logic signed [ostw_pkg::SAMPLE_BITS-1:0] wr_data,
	output logic                                   clearing,
	output logic signed [ostw_pkg::SAMPLE_BITS-1:0] rd_data_a,
	output logic signed [ostw_pkg::SAMPLE_BITS-1:0] rd_data_b
);

	localparam int SB = ostw_pkg::SAMPLE_BITS;
	localparam int AW = ostw_pkg::ADDR_W;
	localparam int RW = ostw_pkg::RAMP_R_W;

	logic signed [SB-1:0] mem_q [ostw_pkg::TABLE_DEPTH];
	logic signed [SB-1:0] rd_a_q;
	logic signed [SB-1:0] rd_b_q;

	logic          clearing_q;
	logic [AW-1:0] clr_idx_q;
	logic [SB-1:0] ramp_val_q;
	logic [RW-1:0] ramp_rem_q;

	logic [RW-1:0] rem_sum;
	logic [RW-1:0] rem_nxt;
	logic [SB-1:0] val_nxt;

	// next ramp entry: add quotient step, carry one when remainder wraps
	always_comb begin
		rem_sum = ramp_rem_q + RW'(ostw_pkg::RAMP_RSTEP);
		if (rem_sum >= RW'(ostw_pkg::LAST_IDX)) begin
			rem_nxt = rem_sum - RW'(ostw_pkg::LAST_IDX);
			val_nxt = ramp_val_q + SB'(ostw_pkg::RAMP_QSTEP + 1);
		end else begin
			rem_nxt = rem_sum;
			val_nxt = ramp_val_q + SB'(ostw_pkg::RAMP_QSTEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
			ramp_val_q <= '0;
			ramp_rem_q <= RW'(ostw_pkg::RAMP_RINIT);
		end else if (clearing_q) begin
			clr_idx_q  <= clr_idx_q + AW'(1);
			ramp_val_q <= val_nxt;
			ramp_rem_q <= rem_nxt;
			if (clr_idx_q == AW'(ostw_pkg::LAST_IDX)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_q[clr_idx_q] <= $signed(ramp_val_q);
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	assign clearing  = clearing_q;
	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

@@ rtl/ostw_interp.sv @@
// interpolation multiply stage and saturating output register
module ostw_interp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    valid_s1,
	input  ostw_pkg::ctl_t                          ctl_s1,
	input  logic signed [ostw_pkg::SAMPLE_BITS-1:0] a_s1,
	input  logic signed [ostw_pkg::SAMPLE_BITS-1:0] b_s1,
	output logic                                    take_s1,
	input  logic                                    out_stall,
	output logic                                    out_valid,
	output logic signed [ostw_pkg::SAMPLE_BITS-1:0] sample_out
);

	localparam int SB   = ostw_pkg::SAMPLE_BITS;
	localparam int FB   = ostw_pkg::FRAC_BITS;
	localparam int D_W  = SB + 1;
	localparam int P_W  = 2 * D_W;
	localparam int T_W  = P_W + 1;
	localparam int Y_W  = SB + 4;
	localparam int HALF = 2 ** (FB - 1);
	localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(2 ** (SB - 1) - 1);
	localparam logic signed [Y_W-1:0] Y_MIN = ~Y_MAX;

	logic                  v_s2;
	ostw_pkg::ctl_t        ctl_s2;
	logic signed [SB-1:0]  a_s2;
	logic signed [P_W-1:0] prod_s2;

	logic                  valid_q;
	logic signed [SB-1:0]  sample_q;

	logic                  en_out;
	logic                  en_s2;
	logic signed [D_W-1:0] diff;
	logic signed [D_W-1:0] fval;
	logic signed [T_W-1:0] t_full;
	logic signed [Y_W-1:0] y_mag;
	logic signed [Y_W-1:0] y_sgn;
	logic signed [Y_W-1:0] y_sat;

	assign en_out  = !valid_q || !out_stall;
	assign en_s2   = !v_s2 || en_out;
	assign take_s1 = en_s2;

	// a*(1-f) + b*f rewritten as a + (b-a)*f
	always_comb begin
		diff = D_W'(b_s1) - D_W'(a_s1);
		fval = D_W'({ctl_s1.frac, {ostw_pkg::ADDR_W{1'b0}}});
	end

	always_comb begin
		t_full = (T_W'(a_s2) <<< FB) + T_W'(prod_s2) + T_W'(HALF);
		y_mag  = Y_W'(t_full >>> FB);
		y_sgn  = ctl_s2.neg ? -y_mag : y_mag;
		if (y_sgn > Y_MAX) begin
			y_sat = Y_MAX;
		end else if (y_sgn < Y_MIN) begin
			y_sat = Y_MIN;
		end else begin
			y_sat = y_sgn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= valid_s1;
			end
			if (en_out) begin
				valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctl_s2  <= ctl_s1;
			a_s2    <= a_s1;
			prod_s2 <= diff * fval;
		end
		if (en_out) begin
			sample_q <= ctl_s2.pass ? ctl_s2.sample : SB'(y_sat);
		end
	end

	assign out_valid  = valid_q;
	assign sample_out = sample_q;

endmodule

@@ rtl/odd_symmetric_table_waveshaper.sv @@
// top level of the odd-symmetric table waveshaper
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------------
//  in      | in_valid / in_stall | operation, sample_in, entry_index, entry_value
//  out     | out_valid/out_stall | sample_out
//
// one transaction per cycle while out_stall stays low; a shaped sample passes three
// registers (table read register, multiply register, output register) before
// out_valid rises, and uses the two table read ports and the one multiplier.
// after reset the table is filled with its ramp, one entry per cycle, for all 512
// entries; in_stall stays high until the fill ends. table writes give no result.
// a stall on out backs up through the pipeline and reaches in_stall only
// when every stage holds a sample.
`include "assert_macros.svh"

module odd_symmetric_table_waveshaper (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    operation,
	input  logic signed [ostw_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic [ostw_pkg::ENTRY_W-1:0]            entry_index,
	input  logic signed [ostw_pkg::SAMPLE_BITS-1:0] entry_value,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [ostw_pkg::SAMPLE_BITS-1:0] sample_out
);

	localparam int SB = ostw_pkg::SAMPLE_BITS;
	localparam int AW = ostw_pkg::ADDR_W;
	localparam int FB = ostw_pkg::FRAC_BITS;

	logic                 accept;
	logic                 acc_shape;
	logic                 acc_write;
	logic                 clearing;
	logic                 en_s1;
	logic                 take_s1;
	logic                 valid_s1;
	ostw_pkg::ctl_t       ctl_s1;
	ostw_pkg::ctl_t       ctl_in;
	logic signed [SB-1:0] a_s1;
	logic signed [SB-1:0] b_s1;

	logic [SB-1:0]        mag;
	logic [AW-1:0]        idx_lo;
	logic [AW-1:0]        idx_hi;
	logic                 wr_ok;

	// first stage advances when empty or when the multiply stage takes it
	assign en_s1     = !valid_s1 || take_s1;
	assign in_stall  = clearing || !en_s1;
	assign accept    = in_valid && !in_stall;
	assign acc_shape = accept && (operation == ostw_pkg::OP_SHAPE);
	assign acc_write = accept && (operation == ostw_pkg::OP_WRITE);

	// magnitude, table index and fraction of the incoming sample
	always_comb begin
		mag           = sample_in[SB-1] ? SB'(-sample_in) : SB'(sample_in);
		idx_lo        = mag[FB-1 -: AW];
		idx_hi        = (idx_lo == AW'(ostw_pkg::LAST_IDX)) ? idx_lo : idx_lo + AW'(1);
		ctl_in.neg    = sample_in[SB-1];
		// zero and minus full scale bypass the curve
		ctl_in.pass   = (sample_in == '0) || (sample_in == {1'b1, {(SB-1){1'b0}}});
		ctl_in.frac   = mag[ostw_pkg::IDX_FRAC_W-1:0];
		ctl_in.sample = sample_in;
	end

	// writes past the end of the table are dropped
	assign wr_ok = (32'(entry_index) < ostw_pkg::TABLE_DEPTH);

	ostw_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (en_s1),
		.rd_addr_a (idx_lo),
		.rd_addr_b (idx_hi),
		.wr_en     (acc_write && wr_ok),
		.wr_addr   (AW'(entry_index)),
		.wr_data   (entry_value),
		.clearing  (clearing),
		.rd_data_a (a_s1),
		.rd_data_b (b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= acc_shape;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctl_s1 <= ctl_in;
		end
	end

	ostw_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.ctl_s1     (ctl_s1),
		.a_s1       (a_s1),
		.b_s1       (b_s1),
		.take_s1    (take_s1),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.sample_out (sample_out)
	);

	// no transaction is taken while the ramp fill runs
	`ASSERT_IMPLY(a_no_accept_in_fill, clearing, in_stall, "input accepted during table fill")
	// an accepted shape transaction occupies the first stage next cycle
	`ASSERT_CLK(a_shape_enters_s1, acc_shape |=> valid_s1, "shape transaction lost")
	// a table write never creates a pipeline entry
	`ASSERT_CLK(a_write_no_entry, acc_write |=> !valid_s1, "table write produced an entry")

endmodule
